// ===== rtl/trailing_whitespace_stripper_core_macros.svh =====
// assertion macros for the trailing whitespace stripper
// used by the port checker; no other dependencies
`ifndef TRAILING_WHITESPACE_STRIPPER_CORE_MACROS_SVH
`define TRAILING_WHITESPACE_STRIPPER_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define TWS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define TWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tws_pkg.sv =====
// shared types and character constants for the trailing whitespace stripper
// no dependencies
`timescale 1ns / 1ps

package tws_pkg;

  // characters with special handling
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;

  // input action codes
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_EOS  = 1'b1;

  // source of an output beat
  typedef enum logic [1:0] {
    OSEL_HEAD,
    OSEL_INPUT,
    OSEL_HOLD
  } out_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     clear;
    logic     push;
    logic     pop;
    logic     hold_load;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
    logic     out_ovf;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_eos;
    logic is_ws;
    logic is_nl;
    logic full;
    logic count_zero;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/tws_datapath.sv =====
// datapath: pending whitespace shift register, held text byte, output register
// depends on tws_pkg
`timescale 1ns / 1ps

module tws_datapath #(
  parameter int MAX_PENDING = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              action,
  input  logic [7:0]        data_byte,
  input  tws_pkg::cmd_t     cmd,
  output tws_pkg::status_t  status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              last_of_run,
  output logic              overflowed
);

  localparam int CW = $clog2(MAX_PENDING + 1);
  localparam int IW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;

  logic [MAX_PENDING-1:0] pending;
  logic [MAX_PENDING-1:0] pending_next;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [7:0]             hold;
  logic                   in_kind;
  logic [7:0]             head_byte;
  logic [7:0]             sel_byte;

  // classify the incoming beat
  assign in_kind = (data_byte == tws_pkg::CH_TAB);
  assign status.is_eos     = (action == tws_pkg::ACT_EOS);
  assign status.is_ws      = (data_byte == tws_pkg::CH_SPACE) || in_kind;
  assign status.is_nl      = (data_byte == tws_pkg::CH_NEWLINE);
  assign status.full       = (count == CW'(MAX_PENDING));
  assign status.count_zero = (count == '0);
  assign status.out_free   = !out_valid || out_ready;

  // oldest held entry sits at bit 0
  assign head_byte = pending[0] ? tws_pkg::CH_TAB : tws_pkg::CH_SPACE;

  // pending run: pop shifts toward bit 0, push writes behind the last entry
  always_comb begin
    pending_next = pending;
    if (cmd.pop) begin
      pending_next = pending >> 1;
    end
    if (cmd.push) begin
      if (cmd.pop) begin
        pending_next[MAX_PENDING-1] = in_kind;
      end else begin
        pending_next[count[IW-1:0]] = in_kind;
      end
    end
  end

  // entry count
  always_comb begin
    count_next = count;
    if (cmd.clear) begin
      count_next = '0;
    end else if (cmd.push && !cmd.pop) begin
      count_next = count + CW'(1);
    end else if (cmd.pop && !cmd.push) begin
      count_next = count - CW'(1);
    end
  end

  // output byte source
  always_comb begin
    case (cmd.out_sel)
      tws_pkg::OSEL_HEAD:  sel_byte = head_byte;
      tws_pkg::OSEL_INPUT: sel_byte = data_byte;
      tws_pkg::OSEL_HOLD:  sel_byte = hold;
      default:             sel_byte = data_byte;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pending <= pending_next;
    if (cmd.hold_load) begin
      hold <= data_byte;
    end
    if (cmd.out_load) begin
      out_byte    <= sel_byte;
      last_of_run <= cmd.out_last;
      overflowed  <= cmd.out_ovf;
    end
  end

endmodule

// ===== rtl/tws_ctrl.sv =====
// controller: accepts input beats and sequences the release of a pending run
// depends on tws_pkg
`timescale 1ns / 1ps

module tws_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tws_pkg::status_t status,
  output tws_pkg::cmd_t    cmd
);

  typedef enum logic {
    S_IDLE,
    S_RELEASE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && status.out_free;
  assign accept   = in_valid && in_ready;

  // command decode
  always_comb begin
    cmd        = '0;
    cmd.out_sel = tws_pkg::OSEL_INPUT;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (status.is_eos) begin
            cmd.clear = 1'b1;
          end else if (status.is_ws) begin
            // full store: oldest entry leaves early
            cmd.push = 1'b1;
            if (status.full) begin
              cmd.pop      = 1'b1;
              cmd.out_load = 1'b1;
              cmd.out_sel  = tws_pkg::OSEL_HEAD;
              cmd.out_last = 1'b1;
              cmd.out_ovf  = 1'b1;
            end
          end else if (status.is_nl) begin
            cmd.clear    = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_last = 1'b1;
          end else if (status.count_zero) begin
            cmd.out_load = 1'b1;
            cmd.out_last = 1'b1;
          end else begin
            // text after held whitespace: start releasing the run
            cmd.hold_load = 1'b1;
            cmd.pop       = 1'b1;
            cmd.out_load  = 1'b1;
            cmd.out_sel   = tws_pkg::OSEL_HEAD;
            state_next    = S_RELEASE;
          end
        end
      end
      S_RELEASE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (!status.count_zero) begin
            cmd.pop     = 1'b1;
            cmd.out_sel = tws_pkg::OSEL_HEAD;
          end else begin
            cmd.out_sel  = tws_pkg::OSEL_HOLD;
            cmd.out_last = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/trailing_whitespace_stripper_core.sv =====
// Trailing whitespace stripper. Spaces and tabs are held as a pending run of up
// to MAX_PENDING entries; a newline drops the run, other text releases it ahead
// of itself, and an end-of-stream beat (action = 1) drops it silently. A space
// or tab arriving with the store full pushes the oldest entry out at once with
// overflowed set. Flow control: input beats are accepted only in the idle state
// and while the output register is free; text after n held entries goes out as
// n + 1 beats, one per cycle while out_ready is high, through the single output
// register, and no input is taken until the last beat of the run is loaded.
// Depends on tws_pkg, tws_ctrl and tws_datapath.
`timescale 1ns / 1ps

module trailing_whitespace_stripper_core #(
  parameter int MAX_PENDING = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       overflowed
);

  tws_pkg::cmd_t    cmd;
  tws_pkg::status_t status;

  // sequencing
  tws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // storage and output register
  tws_datapath #(
    .MAX_PENDING (MAX_PENDING)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .action      (action),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .overflowed  (overflowed)
  );

endmodule

// ===== rtl/tws_checker.sv =====
// port-level checks for the trailing whitespace stripper, bound to the top level
// depends on tws_pkg and trailing_whitespace_stripper_core_macros.svh
`timescale 1ns / 1ps
`include "trailing_whitespace_stripper_core_macros.svh"

module tws_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run,
  input logic       overflowed
);

  // a stalled output beat holds
  `TWS_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_byte), "output beat changed while stalled")

  // an early-emitted byte is a single whitespace result
  `TWS_ASSERT(a_ovf_ws, clk, rst, out_valid && overflowed |-> last_of_run && (out_byte == tws_pkg::CH_SPACE || out_byte == tws_pkg::CH_TAB), "overflow beat is not a lone space or tab")

  // no input is taken while a run is being released
  `TWS_ASSERT(a_release_busy, clk, rst, out_valid && !last_of_run |-> !in_ready, "input accepted during run release")

  // released run bytes are whitespace
  `TWS_ASSERT(a_release_ws, clk, rst, out_valid && !last_of_run |-> (out_byte == tws_pkg::CH_SPACE || out_byte == tws_pkg::CH_TAB), "released byte is not whitespace")

  // reset empties the output register
  `TWS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind trailing_whitespace_stripper_core tws_checker u_tws_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .last_of_run (last_of_run),
  .overflowed  (overflowed)
);
